@@ rtl/core/tsp_pkg.sv @@
// ----------------------------------------------------------------------------
// tsp_pkg
// widths, mode codes, path status codes and register indexes shared by the
// trapezoidal speed profile core and its checker
// ----------------------------------------------------------------------------
package tsp_pkg;

  localparam int STATUS_W = 2;
  localparam int SPEED_W  = 24;
  localparam int TICK_W   = 16;
  localparam int RATE_W   = 32;
  localparam int MODE_W   = 3;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;
  localparam int REG_IDX_W = 2;

  // squared speed and its quotient
  localparam int SQ_W      = 2 * SPEED_W;
  localparam int DIV_CNT_W = 6;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(SQ_W - 1);

  // motion modes as seen on the result channel
  localparam logic [MODE_W-1:0] MODE_IDLE   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CRUISE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ACCEL  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DECEL  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_STOP   = 3'd4;

  // path status codes
  localparam logic [STATUS_W-1:0] STATUS_IDLE   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_MOVING = 2'd1;

  // configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_ACCEL_RATE     = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_MAX_SPEED      = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_BRAKE_DISTANCE = 2'd2;

  localparam logic [SPEED_W-1:0] ACCEL_RATE_RST     = 24'd25600;
  localparam logic [SPEED_W-1:0] MAX_SPEED_RST      = 24'd153600;
  localparam logic [SPEED_W-1:0] BRAKE_DISTANCE_RST = 24'd51200;

endpackage

@@ rtl/core/trapezoidal_speed_profile_top.sv @@
// ----------------------------------------------------------------------------
// trapezoidal_speed_profile_top
// per-tick trapezoidal speed profile: accelerate, cruise, brake and stop
// ----------------------------------------------------------------------------
// one request on the in_ channel carries the path status, both distances and
// the tick length; one result on the out_ channel returns the speed and the
// motion mode after that tick. both channels use valid/ready.
// an accepted request goes through one shared 32x24 multiplier and, when
// braking starts, a restoring divider that yields one quotient bit a cycle.
// an ordinary tick runs through the multiply, update and done states; a tick
// that latches the braking rate adds 48 divider steps and a latch state.
// in_ready is high only while the sequencer is idle, so a new request is
// taken in the cycle after the previous result is loaded.
// the result waits in an output register; a stalled receiver holds the
// finished work until the register frees, and a request can still be
// accepted while a result sits in it.
// reset clears mode, speed and braking rate and restores the register
// defaults; registers sit at byte addresses 0, 4 and 8 of the apb port.
// ----------------------------------------------------------------------------
module trapezoidal_speed_profile_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tsp_pkg::ADDR_W-1:0]      paddr,
  input  logic [tsp_pkg::DATA_W-1:0]      pwdata,
  output logic [tsp_pkg::DATA_W-1:0]      prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [tsp_pkg::STATUS_W-1:0]    in_path_status,
  input  logic [tsp_pkg::SPEED_W-1:0]     in_distance_to_destination,
  input  logic [tsp_pkg::SPEED_W-1:0]     in_distance_to_finish,
  input  logic [tsp_pkg::TICK_W-1:0]      in_tick_time,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [tsp_pkg::SPEED_W-1:0]     out_speed,
  output logic [tsp_pkg::MODE_W-1:0]      out_motion_mode
);
  import tsp_pkg::*;

  localparam int MUL_A_W = RATE_W;
  localparam int MUL_B_W = SPEED_W;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int REM_W   = SPEED_W + 1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MUL   = 6'b000010,
    S_UPD   = 6'b000100,
    S_DIV   = 6'b001000,
    S_LATCH = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t               state_r, state_nxt;
  logic [MODE_W-1:0]    mode_r, mode_nxt;
  logic [SPEED_W-1:0]   speed_r, speed_nxt;
  logic [RATE_W-1:0]    brake_rate_r, brake_rate_nxt;

  logic [SPEED_W-1:0]   accel_rate_r;
  logic [SPEED_W-1:0]   max_speed_r;
  logic [SPEED_W-1:0]   brake_dist_r;

  logic [STATUS_W-1:0]  status_r;
  logic [SPEED_W-1:0]   dest_r;
  logic [SPEED_W-1:0]   fin_r;
  logic [TICK_W-1:0]    tick_r;

  logic [PROD_W-1:0]    prod_r;
  logic [REM_W-1:0]     rem_r, rem_nxt;
  logic [SQ_W-1:0]      quo_r, quo_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;

  logic                 out_valid_r;
  logic [SPEED_W-1:0]   out_speed_r;
  logic [MODE_W-1:0]    out_mode_r;

  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 in_acc;
  logic                 out_free;
  logic                 need_brake;
  logic [MUL_A_W-1:0]   mul_a;
  logic [MUL_B_W-1:0]   mul_b;
  logic [PROD_W-1:0]    prod_full;
  logic [SPEED_W-1:0]   accel_step;
  logic [SPEED_W:0]     accel_sum;
  logic [RATE_W-1:0]    decel_step;
  logic [REM_W:0]       div_trial;
  logic [REM_W:0]       div_divisor;

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_idx)
      REG_ACCEL_RATE:     prdata = DATA_W'(accel_rate_r);
      REG_MAX_SPEED:      prdata = DATA_W'(max_speed_r);
      REG_BRAKE_DISTANCE: prdata = DATA_W'(brake_dist_r);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_rate_r <= ACCEL_RATE_RST;
      max_speed_r  <= MAX_SPEED_RST;
      brake_dist_r <= BRAKE_DISTANCE_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_ACCEL_RATE:     accel_rate_r <= pwdata[SPEED_W-1:0];
        REG_MAX_SPEED:      max_speed_r  <= pwdata[SPEED_W-1:0];
        REG_BRAKE_DISTANCE: brake_dist_r <= pwdata[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  // handshakes
  assign in_ready        = (state_r == S_IDLE);
  assign in_acc          = in_valid && in_ready;
  assign out_free        = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_speed       = out_speed_r;
  assign out_motion_mode = out_mode_r;

  // shared multiplier
  assign need_brake = ((mode_r == MODE_CRUISE) || (mode_r == MODE_ACCEL)) &&
                      (fin_r < brake_dist_r);

  always_comb begin
    if (need_brake) begin
      mul_a = MUL_A_W'(speed_r);
      mul_b = speed_r;
    end else if (mode_r == MODE_ACCEL) begin
      mul_a = MUL_A_W'(accel_rate_r);
      mul_b = MUL_B_W'(tick_r);
    end else begin
      mul_a = brake_rate_r;
      mul_b = MUL_B_W'(tick_r);
    end
  end

  assign prod_full  = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign accel_step = prod_r[TICK_W +: SPEED_W];
  assign accel_sum  = {1'b0, speed_r} + {1'b0, accel_step};
  assign decel_step = prod_r[TICK_W +: RATE_W];

  // restoring divider, one quotient bit a cycle
  assign div_trial   = {rem_r, quo_r[SQ_W-1]};
  assign div_divisor = {1'b0, brake_dist_r, 1'b0};

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    speed_nxt      = speed_r;
    brake_rate_nxt = brake_rate_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    cnt_nxt        = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_MUL;
      end
      S_MUL: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        state_nxt = S_DONE;
        if (need_brake) begin
          rem_nxt   = '0;
          quo_nxt   = prod_r[SQ_W-1:0];
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end else begin
          case (mode_r)
            MODE_IDLE: begin
              if (status_r == STATUS_MOVING) begin
                mode_nxt = (dest_r > brake_dist_r) ? MODE_ACCEL : MODE_DECEL;
              end else if (status_r != STATUS_IDLE) begin
                mode_nxt = MODE_STOP;
              end
            end
            MODE_CRUISE: ;
            MODE_ACCEL: begin
              if (accel_sum >= {1'b0, max_speed_r}) begin
                speed_nxt = max_speed_r;
                mode_nxt  = MODE_CRUISE;
              end else begin
                speed_nxt = accel_sum[SPEED_W-1:0];
              end
            end
            MODE_DECEL: begin
              if (RATE_W'(speed_r) > decel_step) begin
                speed_nxt = speed_r - decel_step[SPEED_W-1:0];
              end else begin
                speed_nxt = '0;
                mode_nxt  = MODE_STOP;
              end
            end
            default: begin
              speed_nxt = '0;
              mode_nxt  = MODE_IDLE;
            end
          endcase
        end
      end
      S_DIV: begin
        if (div_trial >= div_divisor) begin
          rem_nxt = REM_W'(div_trial - div_divisor);
          quo_nxt = {quo_r[SQ_W-2:0], 1'b1};
        end else begin
          rem_nxt = div_trial[REM_W-1:0];
          quo_nxt = {quo_r[SQ_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) state_nxt = S_LATCH;
      end
      S_LATCH: begin
        // saturate when the quotient overflows the rate register
        brake_rate_nxt = (|quo_r[SQ_W-1:RATE_W]) ? '1 : quo_r[RATE_W-1:0];
        mode_nxt       = MODE_DECEL;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      mode_r       <= MODE_IDLE;
      speed_r      <= '0;
      brake_rate_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      mode_r       <= mode_nxt;
      speed_r      <= speed_nxt;
      brake_rate_r <= brake_rate_nxt;
      if ((state_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      status_r <= in_path_status;
      dest_r   <= in_distance_to_destination;
      fin_r    <= in_distance_to_finish;
      tick_r   <= in_tick_time;
    end
    if (state_r == S_MUL) prod_r <= prod_full;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
    if ((state_r == S_DONE) && out_free) begin
      out_speed_r <= speed_r;
      out_mode_r  <= mode_r;
    end
  end

endmodule

@@ rtl/core/tsp_checker.sv @@
// ----------------------------------------------------------------------------
// tsp_checker
// port-level checks for the trapezoidal speed profile core
// ----------------------------------------------------------------------------
module tsp_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [tsp_pkg::SPEED_W-1:0]  out_speed,
  input logic [tsp_pkg::MODE_W-1:0]   out_motion_mode
);
  import tsp_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_speed) &&
    $stable(out_motion_mode))
    else $error("result changed while stalled");

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_motion_mode <= MODE_STOP)
    else $error("motion mode out of range");

  // idle and stopping always report standstill
  a_standstill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_motion_mode == MODE_IDLE || out_motion_mode == MODE_STOP)
    |-> out_speed == '0)
    else $error("nonzero speed at standstill");

endmodule

bind trapezoidal_speed_profile_top tsp_checker u_tsp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_speed       (out_speed),
  .out_motion_mode (out_motion_mode)
);

@@ sim/trapezoidal_speed_profile_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trapezoidal_speed_profile_top_tb
// self-checking bench for the per-tick trapezoidal speed profile
// ----------------------------------------------------------------------------
// tick requests go in on the in_ channel with random gaps. the speed and
// motion mode come back on out_ under random back-pressure. a scoreboard
// class keeps its own copy of the profile state and registers and predicts
// each result. a short directed run covers the status codes, the clamps and
// the braking edge cases. whole journeys with random content follow, mixed
// with noise, under several register settings written over the apb port.
// ----------------------------------------------------------------------------
module trapezoidal_speed_profile_top_tb;
  import tsp_pkg::*;

  localparam logic [STATUS_W-1:0] STATUS_PAUSED  = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_WAITING = 2'd3;
  localparam logic [SPEED_W-1:0]  SPEED_FULL     = '1;
  localparam logic [TICK_W-1:0]   TICK_FULL      = '1;
  localparam int RANDOM_PER_PHASE = 120;
  localparam int STALL_LIMIT      = 2000;
  localparam int SETTLE_CYCLES    = 60;

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic [MODE_W-1:0]  mode;
  } profile_result_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SPEED_W-1:0]  dest;
    logic [SPEED_W-1:0]  fin;
    logic [TICK_W-1:0]   tick;
  } tick_req_t;

  class speed_profile_scoreboard;
    logic [SPEED_W-1:0] accel_rate = ACCEL_RATE_RST;
    logic [SPEED_W-1:0] max_speed  = MAX_SPEED_RST;
    logic [SPEED_W-1:0] brake_dist = BRAKE_DISTANCE_RST;
    logic [MODE_W-1:0]  mode       = MODE_IDLE;
    logic [SPEED_W-1:0] speed      = '0;
    logic [RATE_W-1:0]  brake_rate = '0;
    profile_result_t    expected_q[$];
    int failures = 0;

    function void set_reg(logic [REG_IDX_W-1:0] idx, logic [SPEED_W-1:0] value);
      case (idx)
        REG_ACCEL_RATE:     accel_rate = value;
        REG_MAX_SPEED:      max_speed  = value;
        REG_BRAKE_DISTANCE: brake_dist = value;
        default: ;
      endcase
    endfunction

    function logic [RATE_W-1:0] braking_rate(logic [SPEED_W-1:0] v, logic [SPEED_W-1:0] d);
      logic [63:0] q;
      if (d == '0) return '1;
      q = (64'(v) * 64'(v)) / (64'(d) << 1);
      return (q > 64'hFFFF_FFFF) ? '1 : q[RATE_W-1:0];
    endfunction

    function void note_tick(logic [STATUS_W-1:0] status, logic [SPEED_W-1:0] dest,
                            logic [SPEED_W-1:0] fin, logic [TICK_W-1:0] tick);
      logic [63:0] sum;
      case (mode)
        MODE_IDLE: begin
          if (status == STATUS_MOVING) mode = (dest > brake_dist) ? MODE_ACCEL : MODE_DECEL;
          else if (status != STATUS_IDLE) mode = MODE_STOP;
        end
        MODE_CRUISE: begin
          if (fin < brake_dist) begin
            brake_rate = braking_rate(speed, brake_dist);
            mode = MODE_DECEL;
          end
        end
        MODE_ACCEL: begin
          if (fin < brake_dist) begin
            brake_rate = braking_rate(speed, brake_dist);
            mode = MODE_DECEL;
          end else begin
            sum = ((64'(accel_rate) * 64'(tick)) >> 16) + 64'(speed);
            speed = (sum >= 64'(max_speed)) ? max_speed : sum[SPEED_W-1:0];
            if (speed == max_speed) mode = MODE_CRUISE;
          end
        end
        MODE_DECEL: begin
          sum = (64'(brake_rate) * 64'(tick)) >> 16;
          speed = (64'(speed) > sum) ? speed - sum[SPEED_W-1:0] : '0;
          if (speed == '0) mode = MODE_STOP;
        end
        default: begin
          speed = '0;
          mode = MODE_IDLE;
        end
      endcase
      expected_q.push_back('{speed: speed, mode: mode});
    endfunction

    function void check_result(logic [SPEED_W-1:0] got_speed, logic [MODE_W-1:0] got_mode);
      profile_result_t want;
      bit bad;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result: speed %0d mode %0d", got_speed, got_mode);
        return;
      end
      want = expected_q.pop_front();
      bad = 1'b0;
      if (got_speed !== want.speed) bad = 1'b1;
      if (got_mode !== want.mode) bad = 1'b1;
      if (bad) begin
        failures++;
        if (failures <= 10)
          $display("result mismatch: expected speed %0d mode %0d, got speed %0d mode %0d",
                   want.speed, want.mode, got_speed, got_mode);
      end
    endfunction

    function void report_leftovers();
      if (expected_q.size() != 0) begin
        failures += expected_q.size();
        $display("%0d requests never produced a result", expected_q.size());
      end
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [ADDR_W-1:0]   paddr   = '0;
  logic [DATA_W-1:0]   pwdata  = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  logic                in_valid                   = 1'b0;
  logic                in_ready;
  logic [STATUS_W-1:0] in_path_status             = '0;
  logic [SPEED_W-1:0]  in_distance_to_destination = '0;
  logic [SPEED_W-1:0]  in_distance_to_finish      = '0;
  logic [TICK_W-1:0]   in_tick_time               = '0;
  logic                out_valid;
  logic                out_ready = 1'b1;
  logic [SPEED_W-1:0]  out_speed;
  logic [MODE_W-1:0]   out_motion_mode;

  speed_profile_scoreboard sb = new();

  int ticks_taken   = 0;
  int results_taken = 0;
  int issued        = 0;
  int quiet_cycles  = 0;
  int ready_hold    = 0;
  bit calm          = 1'b0;

  trapezoidal_speed_profile_top dut (
    .clk                        (clk),
    .rst_n                      (rst_n),
    .psel                       (psel),
    .penable                    (penable),
    .pwrite                     (pwrite),
    .paddr                      (paddr),
    .pwdata                     (pwdata),
    .prdata                     (prdata),
    .pready                     (pready),
    .in_valid                   (in_valid),
    .in_ready                   (in_ready),
    .in_path_status             (in_path_status),
    .in_distance_to_destination (in_distance_to_destination),
    .in_distance_to_finish      (in_distance_to_finish),
    .in_tick_time               (in_tick_time),
    .out_valid                  (out_valid),
    .out_ready                  (out_ready),
    .out_speed                  (out_speed),
    .out_motion_mode            (out_motion_mode)
  );

  always #2 clk = ~clk;

  // receiver back-pressure
  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else begin
      out_ready  <= ($urandom_range(9, 0) >= 3);
      ready_hold <= ($urandom_range(9, 0) == 0) ? $urandom_range(40, 8) : $urandom_range(3, 0);
    end
  end

  // handshake monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        sb.check_result(out_speed, out_motion_mode);
        results_taken++;
      end
      if (in_valid && in_ready) begin
        sb.note_tick(in_path_status, in_distance_to_destination, in_distance_to_finish,
                     in_tick_time);
        ticks_taken++;
      end
      if ((out_valid && out_ready) || (in_valid && in_ready) || (psel && penable && pready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  function automatic logic [SPEED_W-1:0] pick_near(int unsigned lo, int unsigned hi);
    int unsigned r;
    r = $urandom_range(9, 0);
    if (r == 0) return SPEED_W'(lo);
    if (r == 1) return SPEED_W'(hi);
    return SPEED_W'($urandom_range(hi, lo));
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(9, 0);
    if (r < 6) return 0;
    if (r < 9) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // mostly well-formed journeys driven by the predicted mode, some noise
  function automatic tick_req_t pick_tick();
    tick_req_t t;
    logic [RATE_W-1:0] rate;
    int r;
    t.status = STATUS_W'($urandom);
    t.dest   = SPEED_W'($urandom);
    t.fin    = SPEED_W'($urandom);
    t.tick   = TICK_W'($urandom);
    if ($urandom_range(99, 0) >= 15) begin
      case (sb.mode)
        MODE_IDLE: begin
          r = $urandom_range(9, 0);
          if (r < 7) t.status = STATUS_MOVING;
          else if (r == 7) t.status = STATUS_IDLE;
          else if (r == 8) t.status = STATUS_PAUSED;
          else t.status = STATUS_WAITING;
          if ($urandom_range(3, 0) == 0 || sb.brake_dist == SPEED_FULL)
            t.dest = pick_near(0, sb.brake_dist);
          else
            t.dest = pick_near(sb.brake_dist + 1, SPEED_FULL);
        end
        MODE_ACCEL, MODE_CRUISE: begin
          if ($urandom_range(9, 0) < ((sb.mode == MODE_ACCEL) ? 1 : 3))
            t.fin = pick_near(0, sb.brake_dist - 1);
          else
            t.fin = pick_near(sb.brake_dist, SPEED_FULL);
          if ($urandom_range(4, 0) == 0) t.tick = $urandom_range(1, 0) ? TICK_FULL : '0;
        end
        MODE_DECEL: t.tick = TICK_W'($urandom_range(TICK_FULL, 16384));
        default: ;
      endcase
    end
    // hold off braking while the latched rate would take too long to stop
    rate = sb.braking_rate(sb.speed, sb.brake_dist);
    if ((sb.mode == MODE_ACCEL || sb.mode == MODE_CRUISE) && t.fin < sb.brake_dist &&
        sb.speed != '0 && (rate < 8 || 64'(rate) * 32 < 64'(sb.speed)))
      t.fin = pick_near(sb.brake_dist, SPEED_FULL);
    return t;
  endfunction

  task automatic send_tick(input logic [STATUS_W-1:0] status, input logic [SPEED_W-1:0] dest,
                           input logic [SPEED_W-1:0] fin, input logic [TICK_W-1:0] tick);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_path_status             <= status;
    in_distance_to_destination <= dest;
    in_distance_to_finish      <= fin;
    in_tick_time               <= tick;
    in_valid                   <= 1'b1;
    issued++;
    wait (ticks_taken == issued);
  endtask

  task automatic drain();
    if (in_valid) in_valid <= 1'b0;
    wait (results_taken >= ticks_taken);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [SPEED_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx) << 2;
    pwdata  <= DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, value);
  endtask

  task automatic apply_settings(input logic [SPEED_W-1:0] accel, input logic [SPEED_W-1:0] top,
                                input logic [SPEED_W-1:0] brake);
    drain();
    write_reg(REG_ACCEL_RATE, accel);
    write_reg(REG_MAX_SPEED, top);
    write_reg(REG_BRAKE_DISTANCE, brake);
  endtask

  task automatic run_random(input int count);
    tick_req_t t;
    int useful;
    int sent;
    useful = 0;
    sent = 0;
    while (useful < count && sent < 4 * count) begin
      t = pick_tick();
      if (!(sb.mode == MODE_IDLE && t.status == STATUS_IDLE)) useful++;
      send_tick(t.status, t.dest, t.fin, t.tick);
      sent++;
      if ($urandom_range(199, 0) == 0) drain();
    end
    drain();
  endtask

  initial begin
    int unsigned top;
    int unsigned brake;
    int unsigned accel;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // status codes from idle
    send_tick(STATUS_IDLE, '0, '0, '0);
    send_tick(STATUS_PAUSED, SPEED_FULL, SPEED_FULL, TICK_FULL);
    send_tick(STATUS_MOVING, '0, '0, '0);
    send_tick(STATUS_WAITING, '0, '0, '0);
    send_tick(STATUS_IDLE, '0, '0, '0);
    // destination exactly at brake distance: decelerate on the stale rate
    send_tick(STATUS_MOVING, BRAKE_DISTANCE_RST, SPEED_FULL, '0);
    send_tick(STATUS_IDLE, '0, '0, TICK_FULL);
    send_tick(STATUS_IDLE, '0, '0, '0);
    // full profile: accelerate to the ceiling, cruise, brake, stop
    send_tick(STATUS_MOVING, SPEED_FULL, SPEED_FULL, '0);
    send_tick(STATUS_MOVING, '0, BRAKE_DISTANCE_RST, TICK_FULL);
    repeat (6) send_tick(STATUS_MOVING, '0, SPEED_FULL, TICK_FULL);
    send_tick(STATUS_MOVING, '0, BRAKE_DISTANCE_RST, TICK_FULL);
    send_tick(STATUS_MOVING, '0, BRAKE_DISTANCE_RST - 1, TICK_FULL);
    send_tick(STATUS_MOVING, '0, '0, 16'd1);
    send_tick(STATUS_MOVING, '0, '0, TICK_FULL);
    send_tick(STATUS_MOVING, '0, '0, '0);
    // ceiling lowered below the current speed
    send_tick(STATUS_MOVING, SPEED_FULL, SPEED_FULL, '0);
    repeat (2) send_tick(STATUS_MOVING, '0, SPEED_FULL, TICK_FULL);
    drain();
    write_reg(REG_MAX_SPEED, 24'd1000);
    send_tick(STATUS_MOVING, '0, SPEED_FULL, '0);
    drain();
    write_reg(REG_MAX_SPEED, MAX_SPEED_RST);
    write_reg(REG_BRAKE_DISTANCE, 24'd1);
    send_tick(STATUS_MOVING, '0, '0, TICK_FULL);
    send_tick(STATUS_MOVING, '0, '0, TICK_FULL);
    send_tick(STATUS_MOVING, '0, '0, '0);
    drain();
    write_reg(REG_BRAKE_DISTANCE, BRAKE_DISTANCE_RST);

    run_random(RANDOM_PER_PHASE);
    apply_settings(SPEED_FULL, SPEED_FULL, SPEED_FULL);
    run_random(RANDOM_PER_PHASE);
    // tiny brake distance saturates the braking rate
    apply_settings(SPEED_FULL, SPEED_FULL, 24'd1);
    run_random(RANDOM_PER_PHASE);
    apply_settings('0, '0, 24'd1);
    run_random(RANDOM_PER_PHASE);
    for (int p = 0; p < 2; p++) begin
      top   = $urandom_range(2000000, 10000);
      brake = $urandom_range((16 * top > 32'hFF_FFFF) ? 32'hFF_FFFF : 16 * top, 256);
      accel = $urandom_range((4 * top > 32'hFF_FFFF) ? 32'hFF_FFFF : 4 * top, top / 8);
      calm  = (p == 1);
      apply_settings(SPEED_W'(accel), SPEED_W'(top), SPEED_W'(brake));
      run_random(RANDOM_PER_PHASE);
    end
    calm = 1'b0;
    apply_settings(ACCEL_RATE_RST, MAX_SPEED_RST, BRAKE_DISTANCE_RST);
    run_random(RANDOM_PER_PHASE);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    sb.report_leftovers();
    if (sb.failures == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/tsp_pkg.sv
rtl/core/trapezoidal_speed_profile_top.sv
rtl/core/tsp_checker.sv
sim/trapezoidal_speed_profile_top_tb.sv
